/* rtl/rsenc_pkg.sv */
// shared types, constants and galois field helpers for the reed-solomon encoder
package rsenc_pkg;

    localparam int MAX_EC_BYTES = 32;
    localparam int EC_W         = $clog2(MAX_EC_BYTES + 1);
    localparam int BYTE_W       = 8;
    localparam int LEN_W        = 8;
    localparam int SUM_W        = LEN_W + 1;

    localparam logic [EC_W-1:0]   EC_RESET      = EC_W'(10);
    localparam logic [EC_W-1:0]   EC_MAX        = EC_W'(MAX_EC_BYTES);
    localparam logic [LEN_W-1:0]  MAX_CODEWORD  = LEN_W'(255);
    // low byte of x^8 + x^4 + x^3 + x^2 + 1
    localparam logic [BYTE_W-1:0] FIELD_POLY_LO = 8'h1D;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [MAX_EC_BYTES-1:0][BYTE_W-1:0] byte_vec_t;

    // generator state seen by the datapath; coef[j] is g[j+1]
    typedef struct packed {
        logic            busy;
        logic [EC_W-1:0] n;
        byte_vec_t       coef;
    } gen_info_t;

    // request to load a finished message into the output buffer
    typedef struct packed {
        logic            load;
        logic            err;
        logic [EC_W-1:0] count;
        byte_vec_t       bytes;
    } obuf_load_t;

    function automatic byte_t gf_mul2(input byte_t x);
        gf_mul2 = {x[BYTE_W-2:0], 1'b0} ^ (x[BYTE_W-1] ? FIELD_POLY_LO : '0);
    endfunction

    function automatic byte_t gf_mul(input byte_t a, input byte_t b);
        byte_t x;
        byte_t acc;
        x   = a;
        acc = '0;
        for (int i = 0; i < BYTE_W; i++)
        begin
            if (b[i])
            begin
                acc = acc ^ x;
            end
            x = gf_mul2(x);
        end
        gf_mul = acc;
    endfunction

endpackage

/* rtl/rsenc_if.sv */
// valid/ready channel interfaces for message bytes and check bytes
interface rsenc_in_if;
    import rsenc_pkg::*;

    logic  valid;
    logic  ready;
    byte_t data_byte;
    logic  last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface rsenc_out_if;
    import rsenc_pkg::*;

    logic  valid;
    logic  ready;
    byte_t check_byte;
    logic  last_check;
    logic  length_error;

    modport source (output valid, output check_byte, output last_check,
                    output length_error, input ready);
    modport sink (input valid, input check_byte, input last_check,
                  input length_error, output ready);
endinterface

/* rtl/rsenc_gen.sv */
// generator polynomial builder: one root multiplied in per cycle
module rsenc_gen (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [rsenc_pkg::EC_W-1:0]    cfg_wdata,
    output rsenc_pkg::gen_info_t          info
);
    import rsenc_pkg::*;

    byte_vec_t       coef_reg;
    byte_vec_t       coef_next;
    byte_t           root_reg;
    logic [EC_W-1:0] step_reg;
    logic [EC_W-1:0] n_reg;
    logic            busy;
    logic            wdata_ok;

    assign busy     = step_reg != n_reg;
    assign wdata_ok = (cfg_wdata != '0) && (cfg_wdata <= EC_MAX);

    // multiply g(x) by (x + root): all coefficients in parallel
    always_comb
    begin
        coef_next[0] = coef_reg[0] ^ root_reg;
        for (int j = 1; j < MAX_EC_BYTES; j++)
        begin
            coef_next[j] = coef_reg[j] ^ gf_mul(coef_reg[j-1], root_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
            root_reg <= byte_t'(1);
            step_reg <= '0;
            n_reg    <= EC_RESET;
        end
        else if (cfg_we)
        begin
            coef_reg <= '0;
            root_reg <= byte_t'(1);
            step_reg <= '0;
            // an out-of-range count is kept as zero: every message errors
            n_reg    <= wdata_ok ? cfg_wdata : '0;
        end
        else if (busy)
        begin
            coef_reg <= coef_next;
            root_reg <= gf_mul2(root_reg);
            step_reg <= step_reg + EC_W'(1);
        end
    end

    assign info.busy = busy;
    assign info.n    = n_reg;
    assign info.coef = coef_reg;

`ifndef NO_ASSERTIONS
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= n_reg)
        else $error("generator step ran past count");
`endif

endmodule

/* rtl/rsenc_lfsr.sv */
// input register, message length tracking and parity shift register
module rsenc_lfsr (
    input  logic                          clk,
    input  logic                          rst_n,
    rsenc_in_if.sink                      msg,
    input  rsenc_pkg::gen_info_t          info,
    input  logic                          cfg_we,
    input  logic                          obuf_free,
    output rsenc_pkg::obuf_load_t         load
);
    import rsenc_pkg::*;

    logic             s1_valid_reg;
    byte_t            s1_data_reg;
    logic             s1_last_reg;
    byte_vec_t        par_reg;
    byte_vec_t        par_upd;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_inc;
    logic             ovf_reg;
    logic             ovf_now;
    logic [SUM_W-1:0] len_sum;
    byte_t            fb;
    logic             s1_adv;
    logic             accept;
    logic             msg_err;

    // a last byte waits here until the output buffer can take its check bytes
    assign s1_adv    = s1_valid_reg && (!s1_last_reg || obuf_free);
    assign msg.ready = !info.busy && (!s1_valid_reg || s1_adv);
    assign accept    = msg.valid && msg.ready;

    assign len_inc = (len_reg == MAX_CODEWORD) ? len_reg : len_reg + LEN_W'(1);
    assign len_sum = {1'b0, len_inc} + {{(SUM_W-EC_W){1'b0}}, info.n};
    assign ovf_now = ovf_reg || (len_sum > {1'b0, MAX_CODEWORD});
    assign msg_err = (info.n == '0) || ovf_now;

    assign fb = s1_data_reg ^ par_reg[0];

    always_comb
    begin
        for (int i = 0; i < MAX_EC_BYTES - 1; i++)
        begin
            par_upd[i] = par_reg[i+1] ^ gf_mul(info.coef[i], fb);
        end
        par_upd[MAX_EC_BYTES-1] = gf_mul(info.coef[MAX_EC_BYTES-1], fb);
    end

    always_comb
    begin
        load.load  = s1_adv && s1_last_reg;
        load.err   = msg_err;
        load.count = msg_err ? EC_W'(1) : info.n;
        load.bytes = msg_err ? '0 : par_upd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_data_reg <= msg.data_byte;
            s1_last_reg <= msg.last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            par_reg <= '0;
            len_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (cfg_we || (s1_adv && s1_last_reg))
        begin
            par_reg <= '0;
            len_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            if (!msg_err)
            begin
                par_reg <= par_upd;
            end
            len_reg <= len_inc;
            ovf_reg <= ovf_now;
        end
    end

`ifndef NO_ASSERTIONS
    a_ovf_len: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> ({1'b0, len_reg} + {{(SUM_W-EC_W){1'b0}}, info.n}) > {1'b0, MAX_CODEWORD})
        else $error("overflow flag set for a message that fits");
    a_cfg_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> (len_reg == '0) && !ovf_reg)
        else $error("message state not cleared by count write");
`endif

endmodule

/* rtl/rsenc_obuf.sv */
// output buffer that shifts out the check bytes of one message
module rsenc_obuf (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rsenc_pkg::obuf_load_t         load,
    output logic                          free,
    rsenc_out_if.source                   ecc
);
    import rsenc_pkg::*;

    byte_vec_t       buf_reg;
    logic [EC_W-1:0] rem_reg;
    logic            err_reg;
    logic            take;

    assign ecc.valid        = rem_reg != '0;
    assign ecc.check_byte   = buf_reg[0];
    assign ecc.last_check   = rem_reg == EC_W'(1);
    assign ecc.length_error = err_reg;

    assign take = ecc.valid && ecc.ready;
    assign free = (rem_reg == '0) || ((rem_reg == EC_W'(1)) && ecc.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
            err_reg <= 1'b0;
        end
        else if (load.load)
        begin
            rem_reg <= load.count;
            err_reg <= load.err;
        end
        else if (take)
        begin
            rem_reg <= rem_reg - EC_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load.load)
        begin
            buf_reg <= load.bytes;
        end
        else if (take)
        begin
            for (int i = 0; i < MAX_EC_BYTES - 1; i++)
            begin
                buf_reg[i] <= buf_reg[i+1];
            end
            buf_reg[MAX_EC_BYTES-1] <= '0;
        end
    end

`ifndef NO_ASSERTIONS
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load.load |-> free)
        else $error("check bytes loaded over a busy buffer");
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg <= EC_MAX)
        else $error("remaining count above maximum");
`endif

endmodule

/* rtl/reed_solomon_ecc_encoder_top.sv */
// reed-solomon gf(256) encoder top level
//
//   channel  | dir | handshake    | payload
//   ---------+-----+--------------+----------------------------------------
//   msg      | in  | valid/ready  | data_byte[7:0], last_byte
//   ecc      | out | valid/ready  | check_byte[7:0], last_check, length_error
//   cfg      | in  | cfg_we       | cfg_wdata[5:0] = ec_count
//
// one data byte per cycle while not stalled; the parity update is a single pass of 32 gf multipliers
// a message yields n check bytes, or one error request when too long or n is zero
// after reset or a count write the generator is built one root per cycle, n being 10
// after reset, with msg.ready low meanwhile
// a last byte holds in the input register while the previous check bytes drain
module reed_solomon_ecc_encoder_top (
    input  logic                          clk,
    input  logic                          rst_n,
    rsenc_in_if.sink                      msg,
    rsenc_out_if.source                   ecc,
    input  logic                          cfg_we,
    input  logic [rsenc_pkg::EC_W-1:0]    cfg_wdata
);
    import rsenc_pkg::*;

    gen_info_t  info;
    obuf_load_t load;
    logic       obuf_free;

    rsenc_gen u_gen (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .info      (info)
    );

    rsenc_lfsr u_lfsr (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg       (msg),
        .info      (info),
        .cfg_we    (cfg_we),
        .obuf_free (obuf_free),
        .load      (load)
    );

    rsenc_obuf u_obuf (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (load),
        .free  (obuf_free),
        .ecc   (ecc)
    );

endmodule

/* tb/sv/reed_solomon_ecc_encoder_top_test.sv */
// self-checking testbench for the reed-solomon check byte encoder top level
`timescale 1ns / 100ps

module reed_solomon_ecc_encoder_top_test;
    import rsenc_pkg::*;

    localparam int SETTLE_CYCLES = 48;
    localparam int HOLD_CYCLES   = 400;
    localparam int RAND_ITEMS    = 110;
    localparam int CODEWORD_MAX  = 255;
    localparam int TIMEOUT_NS    = 3_000_000;

    typedef enum logic [1:0] {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_e;
    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_COMB, RX_LIGHT} rx_mode_e;

    typedef struct packed {
        byte_t data;
        logic  last;
    } msg_req_t;

    typedef struct packed {
        byte_t check;
        logic  last;
        logic  err;
    } check_req_t;

    logic            clk       = 1'b0;
    logic            rst_n     = 1'b0;
    logic            cfg_we    = 1'b0;
    logic [EC_W-1:0] cfg_wdata = '0;
    logic            tx_valid  = 1'b0;
    byte_t           tx_data   = '0;
    logic            tx_last   = 1'b0;
    logic            rx_ready  = 1'b0;
    logic            msg_fire  = 1'b0;

    rsenc_in_if  msg_if ();
    rsenc_out_if ecc_if ();

    assign msg_if.valid     = tx_valid;
    assign msg_if.data_byte = tx_data;
    assign msg_if.last_byte = tx_last;
    assign ecc_if.ready     = rx_ready;

    reed_solomon_ecc_encoder_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg       (msg_if),
        .ecc       (ecc_if),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // encoder state as predicted
    logic [EC_W-1:0] ec_count_m;
    byte_t           gen_coef [0:MAX_EC_BYTES];
    byte_t           parity_m [0:MAX_EC_BYTES-1];
    int              msg_len_m;
    logic            overflow_m;

    msg_req_t   msg_pending_q[$];
    check_req_t check_expect_q[$];

    int fail_count   = 0;
    int bytes_taken  = 0;
    int messages     = 0;
    int results_seen = 0;
    int cfg_writes   = 0;
    int hold_req     = 0;

    function automatic byte_t gf_product(input byte_t a, input byte_t b);
        byte_t p;
        p = 8'h00;
        // horner form, top bit of b first
        for (int i = BYTE_W - 1; i >= 0; i--)
        begin
            p = {p[BYTE_W-2:0], 1'b0} ^ (p[BYTE_W-1] ? FIELD_POLY_LO : 8'h00);
            if (b[i])
            begin
                p = p ^ a;
            end
        end
        return p;
    endfunction

    function automatic bit count_ok(input logic [EC_W-1:0] n);
        return (n >= 1) && (n <= MAX_EC_BYTES);
    endfunction

    task automatic clear_message_m;
        foreach (parity_m[i])
        begin
            parity_m[i] = 8'h00;
        end
        msg_len_m  = 0;
        overflow_m = 1'b0;
    endtask

    task automatic load_ec_count(input logic [EC_W-1:0] v);
        byte_t root;
        int    n;
        ec_count_m = v;
        foreach (gen_coef[k])
        begin
            gen_coef[k] = 8'h00;
        end
        gen_coef[0] = 8'h01;
        if (count_ok(v))
        begin
            n    = int'(v);
            root = 8'h01;
            // multiply in (x + 2^i) one root at a time
            for (int i = 0; i < n; i++)
            begin
                for (int k = i + 1; k >= 1; k--)
                begin
                    gen_coef[k] = gen_coef[k] ^ gf_product(gen_coef[k-1], root);
                end
                root = gf_product(root, 8'h02);
            end
        end
        clear_message_m();
    endtask

    task automatic absorb_byte(input msg_req_t req);
        bit         ok;
        int         n;
        byte_t      fb;
        check_req_t r;
        ok = count_ok(ec_count_m);
        n  = ok ? int'(ec_count_m) : 0;
        if (msg_len_m < CODEWORD_MAX)
        begin
            msg_len_m++;
        end
        if (msg_len_m + n > CODEWORD_MAX)
        begin
            overflow_m = 1'b1;
        end
        if (ok && !overflow_m)
        begin
            fb = req.data ^ parity_m[0];
            for (int i = 0; i + 1 < n; i++)
            begin
                parity_m[i] = parity_m[i+1] ^ gf_product(gen_coef[i+1], fb);
            end
            parity_m[n-1] = gf_product(gen_coef[n], fb);
        end
        if (req.last)
        begin
            messages++;
            if (!ok || overflow_m)
            begin
                r.check = 8'h00;
                r.last  = 1'b1;
                r.err   = 1'b1;
                check_expect_q.push_back(r);
            end
            else
            begin
                for (int i = 0; i < n; i++)
                begin
                    r.check = parity_m[i];
                    r.last  = (i == n - 1);
                    r.err   = 1'b0;
                    check_expect_q.push_back(r);
                end
            end
            clear_message_m();
        end
    endtask

    // monitor: check results first, then record the accepted request
    always @(posedge clk)
    begin : sample_channels
        check_req_t want;
        msg_req_t   req;
        msg_fire = 1'b0;
        if (rst_n)
        begin
            if (ecc_if.valid === 1'b1 && rx_ready)
            begin
                results_seen++;
                if (check_expect_q.size() == 0)
                begin
                    fail_count++;
                    $error("unexpected check byte %02h", ecc_if.check_byte);
                end
                else
                begin
                    want = check_expect_q.pop_front();
                    if (ecc_if.check_byte !== want.check)
                    begin
                        fail_count++;
                        $error("check_byte: expected %02h, actual %02h",
                               want.check, ecc_if.check_byte);
                    end
                    if (ecc_if.last_check !== want.last)
                    begin
                        fail_count++;
                        $error("last_check: expected %0b, actual %0b",
                               want.last, ecc_if.last_check);
                    end
                    if (ecc_if.length_error !== want.err)
                    begin
                        fail_count++;
                        $error("length_error: expected %0b, actual %0b",
                               want.err, ecc_if.length_error);
                    end
                end
            end
            if (tx_valid && msg_if.ready === 1'b1)
            begin
                msg_fire = 1'b1;
                bytes_taken++;
                req.data = tx_data;
                req.last = tx_last;
                absorb_byte(req);
            end
        end
    end

    // sender: bursts of random length with random gaps
    int burst_left = 1;
    int gap_left   = 0;

    always @(negedge clk)
    begin : drive_msg
        msg_req_t nxt;
        bit       give;
        give = 1'b0;
        if (!tx_valid || msg_fire)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
            end
            else if (msg_pending_q.size() > 0)
            begin
                nxt  = msg_pending_q.pop_front();
                give = 1'b1;
                if (burst_left > 1)
                begin
                    burst_left--;
                end
                else
                begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            tx_valid <= give;
            if (give)
            begin
                tx_data <= nxt.data;
                tx_last <= nxt.last;
            end
        end
    end

    // receiver: stall pattern of its own, plus a long hold-off on request
    rx_mode_e rx_mode   = RX_OPEN;
    int       mode_left = 0;
    int       rx_cycle  = 0;
    int       hold_seen = 0;
    int       hold_left = 0;

    always @(negedge clk)
    begin : drive_ready
        logic rdy;
        rx_cycle++;
        if (hold_seen != hold_req)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rdy = 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                rx_mode   = rx_mode_e'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 80);
            end
            else
            begin
                mode_left--;
            end
            case (rx_mode)
                RX_OPEN:  rdy = 1'b1;
                RX_COIN:  rdy = 1'($urandom_range(0, 1));
                RX_COMB:  rdy = (rx_cycle % 4) != 3;
                default:  rdy = $urandom_range(0, 9) != 0;
            endcase
        end
        rx_ready <= rdy;
    end

    task automatic queue_bytes(input int count, input bit with_last, input fill_e fill);
        msg_req_t req;
        for (int i = 0; i < count; i++)
        begin
            case (fill)
                FILL_ZERO: req.data = 8'h00;
                FILL_ONES: req.data = 8'hFF;
                default:   req.data = byte_t'($urandom_range(0, 255));
            endcase
            req.last = with_last && (i == count - 1);
            msg_pending_q.push_back(req);
        end
    endtask

    task automatic wait_idle;
        while (msg_pending_q.size() != 0 || tx_valid || check_expect_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_ec_count(input logic [EC_W-1:0] v);
        wait_idle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        load_ec_count(v);
        @(negedge clk);
        cfg_we <= 1'b0;
        cfg_writes++;
    endtask

    initial
    begin : run_stimulus
        int              rand_items;
        int              phase;
        int              budget;
        int              len;
        int              pick;
        logic [EC_W-1:0] v;
        fill_e           fill;
        load_ec_count(EC_RESET);
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset count, all-zero and all-ones data, plain message; then counts 1, 32 and out of range
        queue_bytes(1, 1'b1, FILL_ZERO);
        queue_bytes(1, 1'b1, FILL_ONES);
        queue_bytes(3, 1'b1, FILL_RANDOM);
        write_ec_count(EC_W'(1));
        queue_bytes(2, 1'b1, FILL_ONES);
        write_ec_count(EC_MAX);
        queue_bytes(4, 1'b1, FILL_RANDOM);
        // message cut off by a count write is dropped
        queue_bytes(3, 1'b0, FILL_RANDOM);
        write_ec_count(EC_W'(63));
        queue_bytes(2, 1'b1, FILL_RANDOM);
        write_ec_count(EC_W'(0));
        queue_bytes(1, 1'b1, FILL_ONES);
        write_ec_count(EC_W'(33));
        queue_bytes(1, 1'b1, FILL_RANDOM);

        // length limit at the largest count: exact fit, then one byte over
        write_ec_count(EC_MAX);
        queue_bytes(CODEWORD_MAX - MAX_EC_BYTES, 1'b1, FILL_RANDOM);
        queue_bytes(CODEWORD_MAX - MAX_EC_BYTES + 1, 1'b1, FILL_RANDOM);

        rand_items = 0;
        phase      = 0;
        while (rand_items < RAND_ITEMS)
        begin
            pick = $urandom_range(0, 7);
            if (phase == 0)
                v = EC_W'(1);
            else if (phase == 1)
                v = EC_MAX;
            else if (phase == 2)
                v = EC_W'($urandom_range(8, MAX_EC_BYTES));
            else if (pick == 0)
                v = ($urandom_range(0, 1) != 0) ? EC_W'(0) : EC_W'($urandom_range(33, 63));
            else
                v = EC_W'($urandom_range(1, MAX_EC_BYTES));
            write_ec_count(v);
            budget = (phase == 2) ? 48 : $urandom_range(15, 30);
            while (budget > 0)
            begin
                len  = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60)
                                                   : $urandom_range(1, 12);
                pick = $urandom_range(0, 15);
                fill = (pick == 0) ? FILL_ZERO : (pick == 1) ? FILL_ONES : FILL_RANDOM;
                queue_bytes(len, 1'b1, fill);
                rand_items += len;
                budget     -= len;
            end
            if (phase == 2)
            begin
                hold_req++;
            end
            // dangling bytes, dropped by the next count write
            if ($urandom_range(0, 3) == 0)
            begin
                len = $urandom_range(1, 5);
                queue_bytes(len, 1'b0, FILL_RANDOM);
                rand_items += len;
            end
            phase++;
        end
        wait_idle();

        $display("ran %0d message bytes over %0d messages, %0d check results, %0d count writes",
                 bytes_taken, messages, results_seen, cfg_writes);
        $display("counts 1, 32 and out of range, length limits, one long output stall");
        if (fail_count == 0)
        begin
            $display("reed_solomon_ecc_encoder_top_test passed");
        end
        else
        begin
            $display("reed_solomon_ecc_encoder_top_test failed");
        end
        $finish;
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("reed_solomon_ecc_encoder_top_test failed");
        $finish;
    end

endmodule

/* files.f */
rtl/rsenc_pkg.sv
rtl/rsenc_if.sv
rtl/rsenc_gen.sv
rtl/rsenc_lfsr.sv
rtl/rsenc_obuf.sv
rtl/reed_solomon_ecc_encoder_top.sv
tb/sv/reed_solomon_ecc_encoder_top_test.sv
